/* hdl/pmdu_pkg.sv */
// ----------------------------------------------------------------------------
// pmdu_pkg - particle mass decay update, shared definitions
// Types, fixed-point constants and the exp table generator.
// ----------------------------------------------------------------------------
package pmdu_pkg;

    // pipeline depth
    localparam int unsigned STAGES = 8;

    // configuration port
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NOW_TIME          = 3'd0,
        CFG_NEXT_EVENT_TIME   = 3'd1,
        CFG_RADIUS_SQUARED    = 3'd2,
        CFG_LOSS_FRACTION     = 3'd3,
        CFG_INV_RECOVERY_TIME = 3'd4
    } t_cfg_idx;

    // register reset values
    localparam logic signed [31:0] RST_NOW_TIME          = 32'sd0;
    localparam logic signed [31:0] RST_NEXT_EVENT_TIME   = 32'sh7FFF_FFFF;
    localparam logic [62:0]        RST_RADIUS_SQUARED    = 63'd0;
    localparam logic [15:0]        RST_LOSS_FRACTION     = 16'd6554;
    localparam logic [31:0]        RST_INV_RECOVERY_TIME = 32'd1310720;

    // fixed-point widths and constants
    localparam int unsigned Y_W     = 27;   // x*log2(e), Q7.20
    localparam int unsigned Y_FRAC  = 20;
    localparam int unsigned E_W     = 33;   // exp result, Q1.32
    localparam int unsigned X_LIM_B = 42;   // x >= 2^42 (64.0 in Q.36) -> exp is 0

    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
    localparam logic [E_W-1:0] ONE_Q32 = 33'h1_0000_0000;
    localparam logic [48:0] ONE_Q48 = 49'h1_0000_0000_0000;

    // flags that steer the exp lookup
    typedef struct packed {
        logic neg;  // elapsed time below zero: clamp to 1.0
        logic big;  // elapsed time past the range: clamp to 0
    } t_exp_flags;

    // One entry of the 2^(-k/2^bits) table, Q1.32. Evaluated at elaboration.
    function automatic logic [E_W-1:0] exp_entry(input int unsigned bits,
                                                 input int unsigned k);
        logic [63:0] r;
        logic [63:0] num;
        logic [63:0] res;
        logic [63:0] sbit;
        logic [63:0] t;
        r = 64'd1 << 31;
        for (int unsigned i = 0; i < bits; i++) begin
            num  = r << 32;
            res  = '0;
            sbit = 64'd1 << 62;
            for (int unsigned j = 0; j < 32; j++) begin
                if (num >= res + sbit) begin
                    num = num - (res + sbit);
                    res = (res >> 1) + sbit;
                end else begin
                    res = res >> 1;
                end
                sbit = sbit >> 2;
            end
            r = res;
        end
        t = 64'h1_0000_0000;
        for (int unsigned i = 1; i <= k; i++) begin
            t = (t * r + 64'h8000_0000) >> 32;
        end
        return t[E_W-1:0];
    endfunction

endpackage

/* hdl/pmdu_exp_lut.sv */
// ----------------------------------------------------------------------------
// pmdu_exp_lut - exp(-x) by table and shift
// 2^(-y) with y in Q7.20: table on the top fraction bits, shift by the integer.
// ----------------------------------------------------------------------------
module pmdu_exp_lut #(
    parameter int unsigned TBL_BITS = 8
) (
    input  logic [pmdu_pkg::Y_W-1:0] i_y,
    input  pmdu_pkg::t_exp_flags     i_flg,
    output logic [pmdu_pkg::E_W-1:0] o_e
);

    localparam int unsigned TBL_SIZE = 1 << TBL_BITS;
    localparam int unsigned N_W      = pmdu_pkg::Y_W - pmdu_pkg::Y_FRAC;

    logic [pmdu_pkg::E_W-1:0] w_tbl [TBL_SIZE];
    logic [TBL_BITS-1:0]      w_idx;
    logic [N_W-1:0]           w_n;

    for (genvar k = 0; k < TBL_SIZE; k++) begin : g_tbl
        localparam logic [pmdu_pkg::E_W-1:0] ENTRY = pmdu_pkg::exp_entry(TBL_BITS, k);
        assign w_tbl[k] = ENTRY;
    end

    assign w_idx = i_y[pmdu_pkg::Y_FRAC-1 -: TBL_BITS];
    assign w_n   = i_y[pmdu_pkg::Y_W-1:pmdu_pkg::Y_FRAC];

    always_comb begin
        if (i_flg.neg) begin
            o_e = pmdu_pkg::ONE_Q32;
        end else if (i_flg.big || (|w_n[N_W-1:5])) begin
            o_e = '0;   // shift of 32 or more
        end else begin
            o_e = w_tbl[w_idx] >> w_n[4:0];
        end
    end

endmodule

/* hdl/particle_mass_decay_update.sv */
// ----------------------------------------------------------------------------
// particle_mass_decay_update - per-particle mass decay after a noise event
// Event test on radius and time, then base*(1 - eps*exp(-(now-hit)/tau2)).
// ----------------------------------------------------------------------------
// One particle per beat, one result per particle. The datapath is an
// eight-stage pipeline, s1 to s8; a particle's result is held in s8 and
// leaves from there once the output is ready. While the output is not
// stalled, a new particle can be taken every cycle; throughput is one
// particle per clock, set by the pipeline (no stage chains two multipliers).
// Each stage carries a valid bit and advances when it is empty or the stage
// after it advances, so a stalled output fills the pipe stage by stage before
// input ready drops.
// Configuration registers (current time, next event time, radius squared,
// loss fraction, reciprocal recovery time) are read live by the stages and
// must only be written while no particle is in flight; the config channel
// is always ready and an out-of-range index is ignored. exp(-x) comes from a
// constant table of 2^EXP_TABLE_BITS entries followed by a right shift;
// negative elapsed time clamps exp to 1.0, elapsed*inv >= 64.0 clamps it to 0.
// ----------------------------------------------------------------------------
module particle_mass_decay_update #(
    parameter int unsigned EXP_TABLE_BITS = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,

    // configuration write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [pmdu_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pmdu_pkg::CFG_DATA_W-1:0]    i_cfg_data,

    // particle in
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic signed [31:0]                 i_pos_x,
    input  logic signed [31:0]                 i_pos_y,
    input  logic signed [31:0]                 i_pos_z,
    input  logic [31:0]                        i_base_mass,
    input  logic signed [31:0]                 i_last_hit_time,

    // result out
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [31:0]                        o_new_mass,
    output logic signed [31:0]                 o_new_hit_time
);

    localparam int unsigned NS = pmdu_pkg::STAGES;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic signed [31:0] r_now_time;
    logic signed [31:0] r_next_event_time;
    logic [62:0]        r_radius_squared;
    logic [15:0]        r_loss_fraction;
    logic [31:0]        r_inv_recovery_time;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now_time          <= pmdu_pkg::RST_NOW_TIME;
            r_next_event_time   <= pmdu_pkg::RST_NEXT_EVENT_TIME;
            r_radius_squared    <= pmdu_pkg::RST_RADIUS_SQUARED;
            r_loss_fraction     <= pmdu_pkg::RST_LOSS_FRACTION;
            r_inv_recovery_time <= pmdu_pkg::RST_INV_RECOVERY_TIME;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (pmdu_pkg::t_cfg_idx'(i_cfg_index))
                pmdu_pkg::CFG_NOW_TIME:          r_now_time <= i_cfg_data[31:0];
                pmdu_pkg::CFG_NEXT_EVENT_TIME:   r_next_event_time <= i_cfg_data[31:0];
                pmdu_pkg::CFG_RADIUS_SQUARED:    r_radius_squared <= i_cfg_data[62:0];
                pmdu_pkg::CFG_LOSS_FRACTION:     r_loss_fraction <= i_cfg_data[15:0];
                pmdu_pkg::CFG_INV_RECOVERY_TIME: r_inv_recovery_time <= i_cfg_data[31:0];
                default: ;  // unmapped index: write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pipeline control: stage i moves when empty or stage i+1 moves
    // ------------------------------------------------------------------
    logic [NS-1:0] r_vld;
    logic [NS:0]   w_mov;

    always_comb begin
        w_mov[NS] = i_out_ready;
        for (int i = NS - 1; i >= 0; i--) begin
            w_mov[i] = !r_vld[i] || w_mov[i+1];
        end
    end

    assign o_in_ready  = w_mov[0];
    assign o_out_valid = r_vld[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_mov[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int i = 1; i < NS; i++) begin
                if (w_mov[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // datapath
    // ------------------------------------------------------------------
    // s1: squares of position, event window flag
    logic signed [63:0] n_sqx, n_sqy, n_sqz;
    logic [63:0]        r_s1_sqx, r_s1_sqy, r_s1_sqz;
    logic               r_s1_evt;
    logic [31:0]        r_s1_base;
    logic signed [31:0] r_s1_hit;

    assign n_sqx = 64'(i_pos_x) * 64'(i_pos_x);
    assign n_sqy = 64'(i_pos_y) * 64'(i_pos_y);
    assign n_sqz = 64'(i_pos_z) * 64'(i_pos_z);

    // s2: r^2 against radius, pick the hit time
    logic [63:0]        n_r2;
    logic signed [31:0] n_s2_hit;
    logic [31:0]        r_s2_base;
    logic signed [31:0] r_s2_hit;

    assign n_r2     = r_s1_sqx + r_s1_sqy + r_s1_sqz;     // exact, <= 3*2^62
    assign n_s2_hit = (r_s1_evt && (n_r2 < {1'b0, r_radius_squared})) ?
                      r_now_time : r_s1_hit;

    // s3: elapsed = now - hit, 33 bits signed
    logic [32:0]        n_elapsed;
    logic [31:0]        r_s3_el;
    logic               r_s3_neg;
    logic [31:0]        r_s3_base;
    logic signed [31:0] r_s3_hit;

    assign n_elapsed = {r_now_time[31], r_now_time} - {r_s2_hit[31], r_s2_hit};

    // s4: x = elapsed * 1/tau2, Q.36
    logic [63:0]        n_x;
    logic [63:0]        r_s4_x;
    logic               r_s4_neg;
    logic [31:0]        r_s4_base;
    logic signed [31:0] r_s4_hit;

    assign n_x = 64'(r_s3_el) * 64'(r_inv_recovery_time);

    // s5: y = x * log2(e), Q7.20
    logic [56:0]                  n_yprod;
    logic [pmdu_pkg::Y_W-1:0]     r_s5_y;
    pmdu_pkg::t_exp_flags         r_s5_flg;
    logic [31:0]                  r_s5_base;
    logic signed [31:0]           r_s5_hit;

    assign n_yprod = 57'(r_s4_x[pmdu_pkg::X_LIM_B-1:16]) * 57'(pmdu_pkg::LOG2E_Q30);

    // s6: table and shift
    logic [pmdu_pkg::E_W-1:0]     w_e;
    logic [pmdu_pkg::E_W-1:0]     r_s6_e;
    logic [31:0]                  r_s6_base;
    logic signed [31:0]           r_s6_hit;

    pmdu_exp_lut #(
        .TBL_BITS (EXP_TABLE_BITS)
    ) u_exp_lut (
        .i_y   (r_s5_y),
        .i_flg (r_s5_flg),
        .o_e   (w_e)
    );

    // s7: factor = (1 - eps*e), Q1.32
    logic [48:0]                  n_loss;
    logic [48:0]                  n_factor;
    logic [pmdu_pkg::E_W-1:0]     r_s7_factor;
    logic [31:0]                  r_s7_base;
    logic signed [31:0]           r_s7_hit;

    assign n_loss   = 49'(r_loss_fraction) * 49'(r_s6_e);
    assign n_factor = pmdu_pkg::ONE_Q48 - n_loss;

    // s8: mass = base * factor, never above base
    logic [64:0]        n_mass;
    logic [31:0]        r_s8_mass;
    logic signed [31:0] r_s8_hit;

    assign n_mass = 65'(r_s7_base) * 65'(r_s7_factor);

    always_ff @(posedge i_clk) begin
        if (w_mov[0]) begin
            r_s1_sqx  <= n_sqx;
            r_s1_sqy  <= n_sqy;
            r_s1_sqz  <= n_sqz;
            r_s1_evt  <= (r_now_time > r_next_event_time);
            r_s1_base <= i_base_mass;
            r_s1_hit  <= i_last_hit_time;
        end
        if (w_mov[1]) begin
            r_s2_base <= r_s1_base;
            r_s2_hit  <= n_s2_hit;
        end
        if (w_mov[2]) begin
            r_s3_el   <= n_elapsed[31:0];
            r_s3_neg  <= n_elapsed[32];
            r_s3_base <= r_s2_base;
            r_s3_hit  <= r_s2_hit;
        end
        if (w_mov[3]) begin
            r_s4_x    <= n_x;
            r_s4_neg  <= r_s3_neg;
            r_s4_base <= r_s3_base;
            r_s4_hit  <= r_s3_hit;
        end
        if (w_mov[4]) begin
            r_s5_y        <= n_yprod[56:30];
            r_s5_flg.neg  <= r_s4_neg;
            r_s5_flg.big  <= |r_s4_x[63:pmdu_pkg::X_LIM_B];
            r_s5_base     <= r_s4_base;
            r_s5_hit      <= r_s4_hit;
        end
        if (w_mov[5]) begin
            r_s6_e    <= w_e;
            r_s6_base <= r_s5_base;
            r_s6_hit  <= r_s5_hit;
        end
        if (w_mov[6]) begin
            r_s7_factor <= n_factor[48:16];
            r_s7_base   <= r_s6_base;
            r_s7_hit    <= r_s6_hit;
        end
        if (w_mov[7]) begin
            r_s8_mass <= n_mass[63:32];
            r_s8_hit  <= r_s7_hit;
        end
    end

    assign o_new_mass     = r_s8_mass;
    assign o_new_hit_time = r_s8_hit;

`ifndef NO_ASSERTIONS
    // beats in minus beats out is what the pipe holds
    a_occupancy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> $countones(r_vld) == $past($countones(r_vld))
                 + $past(i_in_valid && o_in_ready) - $past(o_out_valid && i_out_ready))
        else $error("pipeline occupancy does not match the beats");

    // input stalls only with every stage full and the output held
    a_in_stall : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> ((&r_vld) && !i_out_ready))
        else $error("input stalled with room in the pipe");

    // factor never above one
    a_factor_max : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[6] |-> r_s7_factor <= pmdu_pkg::ONE_Q32)
        else $error("mass factor above 1.0");

    // zero exp leaves the full factor
    a_zero_exp : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[5] && w_mov[6] && r_s6_e == '0) |=> r_s7_factor == pmdu_pkg::ONE_Q32)
        else $error("zero exp did not give factor 1.0");
`endif

endmodule
